// ===== design/tssc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssc_pkg
// Shared types and codes for the transaction status page cache.
// ----------------------------------------------------------------------------
package tssc_pkg;

   localparam logic [1:0]  CMD_GET     = 2'd0;
   localparam logic [1:0]  CMD_SET     = 2'd1;
   localparam logic [1:0]  CMD_FLUSH   = 2'd2;

   localparam logic [1:0]  KIND_NONE   = 2'd0;
   localparam logic [1:0]  KIND_HIT    = 2'd1;
   localparam logic [1:0]  KIND_MISS   = 2'd2;

   localparam logic [1:0]  STATUS_MASK = 2'b11;
   localparam logic [63:0] STAMP_MAX   = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_LOOKUP,
      S_VICTIM,
      S_WB,
      S_LOAD,
      S_RD,
      S_RMW,
      S_FLUSH,
      S_DONE
   } state_type;

endpackage

// ===== design/tssc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssc request and response channels
// Valid/ready channels carrying a request and its result.
// ----------------------------------------------------------------------------
interface tssc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [13:0] tx_id;
   logic [1:0]  new_status;

   modport source (output valid, cmd, tx_id, new_status, input ready);
   modport sink   (input valid, cmd, tx_id, new_status, output ready);
endinterface

interface tssc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status_out;
   logic        range_error;
   logic [1:0]  access_kind;
   logic [31:0] hit_count;
   logic [31:0] miss_count;
   logic [2:0]  dirty_count;
   logic [6:0]  pages_in_use;

   modport source (output valid, status_out, range_error, access_kind, hit_count,
                   miss_count, dirty_count, pages_in_use, input ready);
   modport sink   (input valid, status_out, range_error, access_kind, hit_count,
                   miss_count, dirty_count, pages_in_use, output ready);
endinterface

// ===== design/tssc_lru_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssc_lru_search
// Iterative least-stamp search, one frame compared per cycle.
// ----------------------------------------------------------------------------
module tssc_lru_search
   import tssc_pkg::*;
#(
   parameter int NUM_FRAMES = 4,
   localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   stamps [NUM_FRAMES],
   output logic          done,
   output logic [FW-1:0] victim
);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [FW-1:0] idx_ff, idx_in;
   logic [FW-1:0] best_ff, best_in;
   logic [63:0]   best_stamp_ff, best_stamp_in;

   always_comb begin
      busy_in       = busy_ff;
      done_in       = 1'b0;
      idx_in        = idx_ff;
      best_in       = best_ff;
      best_stamp_in = best_stamp_ff;
      if (start) begin
         busy_in       = 1'b1;
         idx_in        = '0;
         best_in       = '0;
         best_stamp_in = STAMP_MAX;
      end else if (busy_ff) begin
         // strict less keeps the lowest index on ties
         if (stamps[idx_ff] < best_stamp_ff) begin
            best_in       = idx_ff;
            best_stamp_in = stamps[idx_ff];
         end
         if (idx_ff == FW'(NUM_FRAMES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      idx_ff        <= idx_in;
      best_ff       <= best_in;
      best_stamp_ff <= best_stamp_in;
   end

   assign done   = done_ff;
   assign victim = best_ff;

endmodule

// ===== design/tx_status_store_lru_page_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tx_status_store_lru_page_cache
// Two-bit transaction status store with an LRU write-back page cache.
// ----------------------------------------------------------------------------
// Requests arrive on req_chan (get, set or flush) and each gives exactly one
// result on rsp_chan. The block works on one request at a time and holds
// req_chan.ready low until its result is in the output register.
// A hit passes through decode, tag compare, one byte read of the frame
// memory, a byte write for a set and the output load; the next request
// can be taken in the cycle after the output load.
// A miss adds a page load, an LRU search when all frames are valid and a
// page write-back when the victim is dirty; these copies go one byte a
// cycle through the write port of one memory and the read port of the
// other. A flush steps through the frames and writes back each dirty one.
// Reset empties the cache, zeroes the counters and leaves one page
// allocated; pages read as zero until written back, so no clearing pass is
// needed and a request may be taken right after reset.
// A stalled receiver holds the result in the output register; one more
// request is taken and worked, then its result waits until the register
// is free. The user must keep PAGE_BYTES and MAX_PAGES powers of 2; the block does not check.
// ----------------------------------------------------------------------------
module tx_status_store_lru_page_cache
   import tssc_pkg::*;
#(
   parameter int NUM_FRAMES = 4,
   parameter int PAGE_BYTES = 64,
   parameter int MAX_PAGES  = 64
) (
   input  logic       clock,
   input  logic       reset,
   tssc_req_if.sink   req_chan,
   tssc_rsp_if.source rsp_chan
);

   localparam int          FW       = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int          BW       = $clog2(PAGE_BYTES);
   localparam int          PW       = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int          PCW      = $clog2(MAX_PAGES + 1);
   localparam logic [31:0] ID_LIMIT = 32'(MAX_PAGES * PAGE_BYTES * 4);

   state_type state_ff, state_in;

   logic [1:0]    cmd_ff, cmd_in;
   logic          range_ok_ff, range_ok_in;
   logic [PW-1:0] page_ff, page_in;
   logic [BW-1:0] byte_ff, byte_in;
   logic [1:0]    slot_ff, slot_in;
   logic [1:0]    val_ff, val_in;
   logic [FW-1:0] frame_ff, frame_in;
   logic [FW-1:0] fidx_ff, fidx_in;
   logic          flushing_ff, flushing_in;
   logic [BW:0]   cnt_ff, cnt_in;
   logic [1:0]    status_ff, status_in;
   logic          rerr_ff, rerr_in;
   logic [1:0]    kind_ff, kind_in;
   logic [31:0]   hits_ff, hits_in;
   logic [31:0]   misses_ff, misses_in;
   logic [63:0]   use_clock_ff, use_clock_in;
   logic [PCW-1:0] page_count_ff, page_count_in;

   logic [63:0]   stamp_ff [NUM_FRAMES];
   logic [63:0]   stamp_in [NUM_FRAMES];
   logic [PW-1:0] tag_ff   [NUM_FRAMES];
   logic [PW-1:0] tag_in   [NUM_FRAMES];
   logic [NUM_FRAMES-1:0] valid_ff, valid_in;
   logic [NUM_FRAMES-1:0] dirty_ff, dirty_in;
   logic [MAX_PAGES-1:0]  written_ff, written_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_kind_ff;
   logic        rsp_rerr_ff;
   logic [31:0] rsp_hits_ff, rsp_misses_ff;
   logic [2:0]  rsp_dirty_ff;
   logic [6:0]  rsp_pages_ff;
   logic        rsp_load;

   // frame and backing memories, one write and one registered read port each
   logic [7:0] fm_mem [2**(FW+BW)];
   logic [7:0] bs_mem [2**(PW+BW)];
   logic              fm_we, bs_we;
   logic [FW+BW-1:0]  fm_waddr, fm_raddr;
   logic [PW+BW-1:0]  bs_waddr, bs_raddr;
   logic [7:0]        fm_wdata, bs_wdata, fm_rdata_ff, bs_rdata_ff;

   logic          req_fire;
   logic          hit_any, inv_any;
   logic [FW-1:0] hit_idx, inv_idx;
   logic          lru_start, lru_done;
   logic [FW-1:0] lru_victim;
   logic          cnt_last, page_alloc, fidx_last;
   logic [BW:0]   cnt_m1;
   logic [13:0]   id_page;
   logic [2:0]    dirty_total;
   logic [7:0]    byte_mod;
   logic [2:0]    bit_pos;

   assign req_fire   = req_chan.valid && req_chan.ready;
   assign cnt_last   = (cnt_ff == (BW+1)'(PAGE_BYTES));
   assign cnt_m1     = cnt_ff - 1'b1;
   assign page_alloc = (PCW'(page_ff) < page_count_ff);
   assign fidx_last  = (fidx_ff == FW'(NUM_FRAMES - 1));
   assign id_page    = req_chan.tx_id >> (BW + 2);
   assign bit_pos    = {slot_ff, 1'b0};

   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      inv_any = 1'b0;
      inv_idx = '0;
      dirty_total = '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
         if (!hit_any && valid_ff[i] && tag_ff[i] == page_ff) begin
            hit_any = 1'b1;
            hit_idx = FW'(i);
         end
         if (!inv_any && !valid_ff[i]) begin
            inv_any = 1'b1;
            inv_idx = FW'(i);
         end
         dirty_total = dirty_total + 3'(valid_ff[i] && dirty_ff[i]);
      end
   end

   always_comb begin
      byte_mod = (fm_rdata_ff & ~(8'(STATUS_MASK) << bit_pos)) | (8'(val_ff) << bit_pos);
   end

   tssc_lru_search #(.NUM_FRAMES(NUM_FRAMES)) u_lru (
      .clock  (clock),
      .reset  (reset),
      .start  (lru_start),
      .stamps (stamp_ff),
      .done   (lru_done),
      .victim (lru_victim)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_DECODE;
         end
         S_DECODE: begin
            if ((cmd_ff == CMD_GET || cmd_ff == CMD_SET) && range_ok_ff) begin
               if (cmd_ff == CMD_SET || page_alloc) state_in = S_LOOKUP;
               else state_in = S_DONE;
            end else if (cmd_ff == CMD_FLUSH) begin
               state_in = S_FLUSH;
            end else begin
               state_in = S_DONE;
            end
         end
         S_LOOKUP: begin
            if (hit_any) state_in = S_RD;
            else if (inv_any) state_in = S_LOAD;
            else state_in = S_VICTIM;
         end
         S_VICTIM: begin
            if (lru_done) state_in = dirty_ff[lru_victim] ? S_WB : S_LOAD;
         end
         S_WB: begin
            if (cnt_last) begin
               if (!flushing_ff) state_in = S_LOAD;
               else if (fidx_last) state_in = S_DONE;
               else state_in = S_FLUSH;
            end
         end
         S_LOAD: begin
            if (cnt_last) state_in = S_RD;
         end
         S_RD: begin
            state_in = S_RMW;
         end
         S_RMW: begin
            state_in = S_DONE;
         end
         S_FLUSH: begin
            if (valid_ff[fidx_ff] && dirty_ff[fidx_ff]) state_in = S_WB;
            else if (fidx_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      cmd_in        = cmd_ff;
      range_ok_in   = range_ok_ff;
      page_in       = page_ff;
      byte_in       = byte_ff;
      slot_in       = slot_ff;
      val_in        = val_ff;
      frame_in      = frame_ff;
      fidx_in       = fidx_ff;
      flushing_in   = flushing_ff;
      cnt_in        = cnt_ff;
      status_in     = status_ff;
      rerr_in       = rerr_ff;
      kind_in       = kind_ff;
      hits_in       = hits_ff;
      misses_in     = misses_ff;
      use_clock_in  = use_clock_ff;
      page_count_in = page_count_ff;
      stamp_in      = stamp_ff;
      tag_in        = tag_ff;
      valid_in      = valid_ff;
      dirty_in      = dirty_ff;
      written_in    = written_ff;
      lru_start     = 1'b0;
      rsp_load      = 1'b0;
      fm_we         = 1'b0;
      fm_waddr      = {frame_ff, cnt_m1[BW-1:0]};
      fm_wdata      = written_ff[page_ff] ? bs_rdata_ff : 8'd0;
      fm_raddr      = {frame_ff, cnt_ff[BW-1:0]};
      bs_we         = 1'b0;
      bs_waddr      = {tag_ff[frame_ff], cnt_m1[BW-1:0]};
      bs_wdata      = fm_rdata_ff;
      bs_raddr      = {page_ff, cnt_ff[BW-1:0]};

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in      = req_chan.cmd;
               range_ok_in = ({18'd0, req_chan.tx_id} < ID_LIMIT);
               page_in     = PW'(id_page);
               byte_in     = req_chan.tx_id[BW+1:2];
               slot_in     = req_chan.tx_id[1:0];
               val_in      = req_chan.new_status;
               status_in   = '0;
               rerr_in     = 1'b0;
               kind_in     = KIND_NONE;
            end
         end
         S_DECODE: begin
            if (cmd_ff == CMD_GET || cmd_ff == CMD_SET) begin
               rerr_in = !range_ok_ff;
               // growth: pages past the old count were never written, so read as zero
               if (range_ok_ff && cmd_ff == CMD_SET && !page_alloc)
                  page_count_in = PCW'(page_ff) + 1'b1;
            end else if (cmd_ff == CMD_FLUSH) begin
               flushing_in = 1'b1;
               fidx_in     = '0;
            end
         end
         S_LOOKUP: begin
            cnt_in = '0;
            if (hit_any) begin
               use_clock_in      = use_clock_ff + 1'b1;
               stamp_in[hit_idx] = use_clock_ff + 1'b1;
               hits_in           = hits_ff + 1'b1;
               kind_in           = KIND_HIT;
               frame_in          = hit_idx;
            end else begin
               misses_in = misses_ff + 1'b1;
               kind_in   = KIND_MISS;
               if (inv_any) frame_in = inv_idx;
               else lru_start = 1'b1;
            end
         end
         S_VICTIM: begin
            if (lru_done) frame_in = lru_victim;
         end
         S_WB: begin
            bs_we  = (cnt_ff != '0);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) begin
               cnt_in                      = '0;
               dirty_in[frame_ff]          = 1'b0;
               written_in[tag_ff[frame_ff]] = 1'b1;
               if (flushing_ff) begin
                  if (fidx_last) flushing_in = 1'b0;
                  else fidx_in = fidx_ff + 1'b1;
               end
            end
         end
         S_LOAD: begin
            fm_we  = (cnt_ff != '0);
            cnt_in = cnt_ff + 1'b1;
            if (cnt_last) begin
               cnt_in             = '0;
               tag_in[frame_ff]   = page_ff;
               valid_in[frame_ff] = 1'b1;
               dirty_in[frame_ff] = 1'b0;
               use_clock_in       = use_clock_ff + 1'b1;
               stamp_in[frame_ff] = use_clock_ff + 1'b1;
            end
         end
         S_RD: begin
            fm_raddr = {frame_ff, byte_ff};
         end
         S_RMW: begin
            if (cmd_ff == CMD_GET) begin
               status_in = 2'((fm_rdata_ff >> bit_pos)) & STATUS_MASK;
            end else begin
               fm_we              = 1'b1;
               fm_waddr           = {frame_ff, byte_ff};
               fm_wdata           = byte_mod;
               dirty_in[frame_ff] = 1'b1;
            end
         end
         S_FLUSH: begin
            cnt_in = '0;
            if (valid_ff[fidx_ff] && dirty_ff[fidx_ff]) begin
               frame_in = fidx_ff;
            end else if (fidx_last) begin
               flushing_in = 1'b0;
            end else begin
               fidx_in = fidx_ff + 1'b1;
            end
         end
         S_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_chan.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         flushing_ff   <= 1'b0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         use_clock_ff  <= '0;
         page_count_ff <= PCW'(1);
         valid_ff      <= '0;
         dirty_ff      <= '0;
         written_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < NUM_FRAMES; i++) begin
            stamp_ff[i] <= '0;
            tag_ff[i]   <= '0;
         end
      end else begin
         state_ff      <= state_in;
         flushing_ff   <= flushing_in;
         hits_ff       <= hits_in;
         misses_ff     <= misses_in;
         use_clock_ff  <= use_clock_in;
         page_count_ff <= page_count_in;
         valid_ff      <= valid_in;
         dirty_ff      <= dirty_in;
         written_ff    <= written_in;
         rsp_valid_ff  <= rsp_valid_in;
         stamp_ff      <= stamp_in;
         tag_ff        <= tag_in;
      end
      cmd_ff      <= cmd_in;
      range_ok_ff <= range_ok_in;
      page_ff     <= page_in;
      byte_ff     <= byte_in;
      slot_ff     <= slot_in;
      val_ff      <= val_in;
      frame_ff    <= frame_in;
      fidx_ff     <= fidx_in;
      cnt_ff      <= cnt_in;
      status_ff   <= status_in;
      rerr_ff     <= rerr_in;
      kind_ff     <= kind_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_rerr_ff   <= rerr_ff;
         rsp_kind_ff   <= kind_ff;
         rsp_hits_ff   <= hits_ff;
         rsp_misses_ff <= misses_ff;
         rsp_dirty_ff  <= dirty_total;
         rsp_pages_ff  <= 7'(page_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (fm_we) fm_mem[fm_waddr] <= fm_wdata;
      fm_rdata_ff <= fm_mem[fm_raddr];
   end

   always_ff @(posedge clock) begin
      if (bs_we) bs_mem[bs_waddr] <= bs_wdata;
      bs_rdata_ff <= bs_mem[bs_raddr];
   end

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status_out   = rsp_status_ff;
   assign rsp_chan.range_error  = rsp_rerr_ff;
   assign rsp_chan.access_kind  = rsp_kind_ff;
   assign rsp_chan.hit_count    = rsp_hits_ff;
   assign rsp_chan.miss_count   = rsp_misses_ff;
   assign rsp_chan.dirty_count  = rsp_dirty_ff;
   assign rsp_chan.pages_in_use = rsp_pages_ff;

endmodule

// ===== test/tx_status_store_lru_page_cache_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tx_status_store_lru_page_cache_tb
// Drives get, set and flush requests through the status page cache. A local
// model of the page store and LRU frames predicts each result; typed rows
// take status, range and kind from the table. Results are checked in order,
// under random idling on both channels and one long result-channel stall.
// ----------------------------------------------------------------------------
module tx_status_store_lru_page_cache_tb;
   import tssc_pkg::*;

   localparam int        FRAMES    = 4;
   localparam int        PG_BYTES  = 64;
   localparam int        PAGES_MAX = 64;
   localparam int        IDS_PG    = PG_BYTES * 4;
   localparam int        ID_END    = PAGES_MAX * IDS_PG;
   localparam logic [1:0] CMD_NOP  = 2'd3;
   localparam int        N_RANDOM  = 1200;
   localparam int        STALL_MAX = 20000;

   typedef struct packed {
      logic [1:0]  status_out;
      logic        range_error;
      logic [1:0]  access_kind;
      logic [31:0] hit_count;
      logic [31:0] miss_count;
      logic [2:0]  dirty_count;
      logic [6:0]  pages_in_use;
   } status_rsp_t;

   typedef struct {
      logic [1:0]  cmd;
      logic [13:0] tx_id;
      logic [1:0]  new_status;
      bit          typed;
      logic [1:0]  status_out;
      logic        range_error;
      logic [1:0]  access_kind;
   } directed_row_t;

   logic clock;
   logic reset;

   tssc_req_if req_chan ();
   tssc_rsp_if rsp_chan ();

   tx_status_store_lru_page_cache u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // model of the page store and its frames
   logic [7:0]  page_mem [PAGES_MAX*PG_BYTES];
   logic [7:0]  frame_mem [FRAMES][PG_BYTES];
   logic [5:0]  frame_page [FRAMES];
   bit          frame_live [FRAMES];
   bit          frame_mod [FRAMES];
   logic [63:0] frame_age [FRAMES];
   logic [63:0] age_clock;
   logic [31:0] hits_seen;
   logic [31:0] misses_seen;
   int          pages_alloc;

   status_rsp_t expected_rsps [$];
   int          mismatches;
   int          idle_cycles;
   int          phase;
   bit          hold_rsp;

   function automatic void model_reset();
      foreach (page_mem[i]) page_mem[i] = '0;
      for (int f = 0; f < FRAMES; f++) begin
         frame_page[f] = '0;
         frame_live[f] = 0;
         frame_mod[f]  = 0;
         frame_age[f]  = '0;
         for (int b = 0; b < PG_BYTES; b++) frame_mem[f][b] = '0;
      end
      age_clock   = '0;
      hits_seen   = '0;
      misses_seen = '0;
      pages_alloc = 1;
   endfunction

   function automatic void write_frame_back(int f);
      if (frame_live[f] && frame_mod[f]) begin
         for (int b = 0; b < PG_BYTES; b++)
            page_mem[frame_page[f]*PG_BYTES + b] = frame_mem[f][b];
         frame_mod[f] = 0;
      end
   endfunction

   function automatic int touch_page(int pg, output logic [1:0] kind);
      int          victim;
      logic [63:0] oldest;
      for (int f = 0; f < FRAMES; f++) begin
         if (frame_live[f] && frame_page[f] == pg) begin
            age_clock++;
            frame_age[f] = age_clock;
            hits_seen++;
            kind = KIND_HIT;
            return f;
         end
      end
      misses_seen++;
      kind   = KIND_MISS;
      victim = -1;
      for (int f = FRAMES-1; f >= 0; f--)
         if (!frame_live[f]) victim = f;
      if (victim < 0) begin
         oldest = STAMP_MAX;
         victim = 0;
         for (int f = 0; f < FRAMES; f++)
            if (frame_age[f] < oldest) begin
               oldest = frame_age[f];
               victim = f;
            end
      end
      write_frame_back(victim);
      for (int b = 0; b < PG_BYTES; b++)
         frame_mem[victim][b] = page_mem[pg*PG_BYTES + b];
      frame_page[victim] = pg[5:0];
      frame_live[victim] = 1;
      frame_mod[victim]  = 0;
      age_clock++;
      frame_age[victim] = age_clock;
      return victim;
   endfunction

   function automatic status_rsp_t predict_status(logic [1:0] cmd, logic [13:0] id,
                                                  logic [1:0] val);
      status_rsp_t r;
      int          pg, byte_idx, sh, f;
      logic [1:0]  kind;
      r = '0;
      pg       = id / IDS_PG;
      byte_idx = (id % IDS_PG) / 4;
      sh       = (id % 4) * 2;
      if (cmd == CMD_GET || cmd == CMD_SET) begin
         if (int'(id) >= ID_END) begin
            r.range_error = 1'b1;
         end else if (cmd == CMD_SET) begin
            while (pages_alloc <= pg) begin
               for (int b = 0; b < PG_BYTES; b++) page_mem[pages_alloc*PG_BYTES + b] = '0;
               pages_alloc++;
            end
            f = touch_page(pg, kind);
            frame_mem[f][byte_idx][sh +: 2] = val;
            frame_mod[f]  = 1;
            r.access_kind = kind;
         end else if (pg < pages_alloc) begin
            f = touch_page(pg, kind);
            r.status_out  = frame_mem[f][byte_idx][sh +: 2];
            r.access_kind = kind;
         end
      end else if (cmd == CMD_FLUSH) begin
         for (int g = 0; g < FRAMES; g++) write_frame_back(g);
      end
      for (int g = 0; g < FRAMES; g++)
         if (frame_live[g] && frame_mod[g]) r.dirty_count++;
      r.hit_count    = hits_seen;
      r.miss_count   = misses_seen;
      r.pages_in_use = pages_alloc[6:0];
      return r;
   endfunction

   // ids for the directed part: extremes, evictions, growth, flush
   directed_row_t directed_rows [] = '{
      '{CMD_GET,   14'd0,     2'd0, 1, 2'd0, 1'b0, KIND_MISS},
      '{CMD_GET,   14'd300,   2'd0, 1, 2'd0, 1'b0, KIND_NONE},
      '{CMD_SET,   14'd0,     2'd3, 1, 2'd0, 1'b0, KIND_HIT},
      '{CMD_GET,   14'd0,     2'd0, 1, 2'd3, 1'b0, KIND_HIT},
      '{CMD_SET,   14'd16383, 2'd2, 1, 2'd0, 1'b0, KIND_MISS},
      '{CMD_GET,   14'd16383, 2'd0, 1, 2'd2, 1'b0, KIND_HIT},
      '{CMD_GET,   14'd16380, 2'd0, 0, 2'd0, 1'b0, KIND_NONE},
      '{CMD_SET,   14'd257,   2'd1, 0, 2'd0, 1'b0, KIND_NONE},
      '{CMD_SET,   14'd514,   2'd2, 0, 2'd0, 1'b0, KIND_NONE},
      '{CMD_SET,   14'd771,   2'd3, 0, 2'd0, 1'b0, KIND_NONE},
      '{CMD_GET,   14'd16383, 2'd0, 0, 2'd0, 1'b0, KIND_NONE},
      '{CMD_GET,   14'd0,     2'd0, 0, 2'd0, 1'b0, KIND_NONE},
      '{CMD_FLUSH, 14'd5555,  2'd3, 1, 2'd0, 1'b0, KIND_NONE},
      '{CMD_SET,   14'd1028,  2'd3, 0, 2'd0, 1'b0, KIND_NONE},
      '{CMD_SET,   14'd1285,  2'd1, 0, 2'd0, 1'b0, KIND_NONE},
      '{CMD_GET,   14'd257,   2'd0, 0, 2'd0, 1'b0, KIND_NONE},
      '{CMD_GET,   14'd0,     2'd0, 0, 2'd0, 1'b0, KIND_NONE},
      '{CMD_NOP,   14'd16383, 2'd3, 1, 2'd0, 1'b0, KIND_NONE},
      '{CMD_SET,   14'd0,     2'd0, 0, 2'd0, 1'b0, KIND_NONE},
      '{CMD_GET,   14'd0,     2'd0, 0, 2'd0, 1'b0, KIND_NONE},
      '{CMD_GET,   14'd8191,  2'd0, 0, 2'd0, 1'b0, KIND_NONE},
      '{CMD_FLUSH, 14'd0,     2'd0, 1, 2'd0, 1'b0, KIND_NONE}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_request(logic [1:0] cmd, logic [13:0] id, logic [1:0] val,
                               bit typed, logic [1:0] t_status, logic t_range,
                               logic [1:0] t_kind);
      status_rsp_t r;
      if (phase == 0) begin
         while ($urandom_range(99) < 22) begin
            req_chan.valid = 1'b0;
            @(negedge clock);
         end
      end else if (phase == 1) begin
         while ($urandom_range(99) < 82) begin
            req_chan.valid = 1'b0;
            @(negedge clock);
         end
      end
      req_chan.valid      = 1'b1;
      req_chan.cmd        = cmd;
      req_chan.tx_id      = id;
      req_chan.new_status = val;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      r = predict_status(cmd, id, val);
      if (typed) begin
         r.status_out  = t_status;
         r.range_error = t_range;
         r.access_kind = t_kind;
      end
      expected_rsps.push_back(r);
      @(negedge clock);
   endtask

   // stimulus
   initial begin
      int          pg;
      logic [1:0]  cmd;
      logic [13:0] id;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.cmd        = CMD_GET;
      req_chan.tx_id      = '0;
      req_chan.new_status = '0;
      phase               = 0;
      hold_rsp            = 0;
      mismatches          = 0;
      model_reset();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].cmd, directed_rows[i].tx_id,
                      directed_rows[i].new_status, directed_rows[i].typed,
                      directed_rows[i].status_out, directed_rows[i].range_error,
                      directed_rows[i].access_kind);

      for (int n = 0; n < N_RANDOM; n++) begin
         phase = (n < N_RANDOM/3) ? 0 : (n < 2*N_RANDOM/3) ? 1 : 2;
         // long result stall while requests keep coming
         if (n == N_RANDOM/2) hold_rsp = 1;
         if (n == N_RANDOM/2 + 6) hold_rsp = 0;
         case ($urandom_range(19))
            0:       cmd = CMD_FLUSH;
            1:       cmd = CMD_NOP;
            2, 3, 4, 5, 6, 7, 8, 9: cmd = CMD_SET;
            default: cmd = CMD_GET;
         endcase
         // mostly a handful of pages so hits, evictions and write-backs mix
         if ($urandom_range(9) == 0) begin
            id = 14'($urandom_range(ID_END-1));
         end else begin
            pg = $urandom_range(6);
            id = 14'(pg*IDS_PG + $urandom_range(IDS_PG-1));
         end
         send_request(cmd, id, 2'($urandom_range(3)), 0, '0, 1'b0, KIND_NONE);
      end
      req_chan.valid = 1'b0;

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0) begin
         $display("** tx_status_store_lru_page_cache: PASSED **");
      end else begin
         $display("** tx_status_store_lru_page_cache: FAILED **");
      end
      $finish;
   end

   // result side ready, with a single counted hold-off when asked
   initial begin
      int hold_left;
      bit held;
      hold_left      = 0;
      held           = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp && !held) begin
            hold_left = 400;
            held      = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready = 1'b0;
         end else if (phase == 0) begin
            rsp_chan.ready = ($urandom_range(99) >= 82);
         end else if (phase == 1) begin
            rsp_chan.ready = ($urandom_range(99) >= 22);
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   // in-order result check
   always @(posedge clock) begin
      status_rsp_t got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.status_out, rsp_chan.range_error, rsp_chan.access_kind,
                 rsp_chan.hit_count, rsp_chan.miss_count, rsp_chan.dirty_count,
                 rsp_chan.pages_in_use};
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("result mismatch: expected %p got %p", want, got);
            end
         end
      end
   end

   // watchdog on cycles with no request or result moving
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_MAX) begin
         $display("** tx_status_store_lru_page_cache: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== filelist.f =====
design/tssc_pkg.sv
design/tssc_if.sv
design/tssc_lru_search.sv
design/tx_status_store_lru_page_cache.sv
test/tx_status_store_lru_page_cache_tb.sv
